// File: rtl/sset_pkg.sv
// shared constants and types for the sparse set table
package sset_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int INDEX_W   = 10;
    localparam int VALUE_W   = 31;
    localparam int SIZE_W    = 11;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_RANGE = 2'd2
    } status_t;

endpackage

// File: rtl/sset_ram.sv
// single-port-write, single-port-read synchronous ram with registered read data
module sset_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: rtl/sparse_set_valid_array.sv
// sparse set table: get/set of one index per word, validity by position and trace stores
// path: an input word passes the position and decide states into the result register
// a new word is taken only after the last one leaves decide, as the position then trace
// ram reads depend; a word waits in decide while a finished result waits at the output
// reset: synchronous active-low aresetn clears slot count, control and size (to DEPTH)
// stores are never cleared; no clearing pass, the block takes words right after reset
module sparse_set_valid_array #(
    parameter int DEPTH = sset_pkg::DEPTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [sset_pkg::SIZE_W-1:0]  cfg_data,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic                         s_kind,
    input  logic [sset_pkg::INDEX_W-1:0] s_index,
    input  logic [sset_pkg::VALUE_W-1:0] s_value,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [sset_pkg::VALUE_W-1:0] m_read_value
);
    import sset_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [31:0] DEPTH_U = 32'(DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_POS  = 3'b010,
        ST_DEC  = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    logic                 kind_reg;
    logic [AW-1:0]        addr_reg;
    logic [VALUE_W-1:0]   value_reg;
    logic                 range_ok_reg;
    logic [CW-1:0]        count_reg;
    logic [SIZE_W-1:0]    size_reg;
    logic                 m_valid_reg;
    status_t              m_status_reg, m_status_next;
    logic [VALUE_W-1:0]   m_read_value_reg, m_read_value_next;

    logic                 s_fire;
    logic                 advance;
    logic                 entry_valid;
    logic                 trace_full;
    logic                 do_append;
    logic                 do_value_wr;

    logic [AW-1:0]        pos_rd;
    logic [AW-1:0]        trace_rd;
    logic [VALUE_W-1:0]   value_rd;

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign advance   = (state_reg == ST_DEC) && (!m_valid_reg || m_ready);

    // unwritten store entries count as not valid
    always_comb begin
        entry_valid = 1'b0;
        if ((CW'(pos_rd) < count_reg) && (trace_rd == addr_reg)) begin
            entry_valid = 1'b1;
        end
    end

    assign trace_full  = (count_reg == CW'(DEPTH));
    assign do_append   = advance && range_ok_reg && kind_reg && !entry_valid && !trace_full;
    assign do_value_wr = advance && range_ok_reg && kind_reg && (entry_valid || !trace_full);

    // position store: index to slot
    sset_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_pos_ram (
        .aclk    (aclk),
        .wr_en   (do_append),
        .wr_addr (addr_reg),
        .wr_data (count_reg[AW-1:0]),
        .rd_en   (s_fire),
        .rd_addr (AW'(s_index)),
        .rd_data (pos_rd)
    );

    // trace store: slot back to index
    sset_ram #(.WIDTH(AW), .DEPTH(DEPTH)) u_trace_ram (
        .aclk    (aclk),
        .wr_en   (do_append),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (addr_reg),
        .rd_en   (state_reg == ST_POS),
        .rd_addr (pos_rd),
        .rd_data (trace_rd)
    );

    sset_ram #(.WIDTH(VALUE_W), .DEPTH(DEPTH)) u_value_ram (
        .aclk    (aclk),
        .wr_en   (do_value_wr),
        .wr_addr (addr_reg),
        .wr_data (value_reg),
        .rd_en   (s_fire),
        .rd_addr (AW'(s_index)),
        .rd_data (value_rd)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next = ST_POS;
                end
            end
            ST_POS: begin
                state_next = ST_DEC;
            end
            ST_DEC: begin
                if (advance) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_status_next     = STATUS_OK;
        m_read_value_next = '0;
        priority if (!range_ok_reg) begin
            m_status_next = STATUS_RANGE;
        end else if (!kind_reg) begin
            if (entry_valid) begin
                m_read_value_next = value_rd;
            end else begin
                m_status_next = STATUS_EMPTY;
            end
        end else begin
            m_status_next = STATUS_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            size_reg    <= SIZE_W'(DEPTH);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                size_reg <= cfg_data;
            end
            if (do_append) begin
                count_reg <= count_reg + 1'b1;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            kind_reg     <= s_kind;
            addr_reg     <= AW'(s_index);
            value_reg    <= s_value;
            range_ok_reg <= (s_index < size_reg) && (32'(s_index) < DEPTH_U);
        end
        if (advance) begin
            m_status_reg     <= m_status_next;
            m_read_value_reg <= m_read_value_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_read_value = m_read_value_reg;

endmodule

// File: rtl/sset_chk.sv
// port-level checker for the sparse set table and its bind
module sset_chk (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [1:0]                   m_status,
    input logic [sset_pkg::VALUE_W-1:0] m_read_value
);
    import sset_pkg::*;

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_read_value))
        else $error("result word changed while stalled");

    // only a successful get carries a value
    a_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status != STATUS_OK) |-> m_read_value == '0)
        else $error("nonzero read value on empty or out of range result");

    // one word in flight
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a word is in flight");

    // result follows the input word through the position and decide states when output is free
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (!m_valid || m_ready) |-> ##3 m_valid)
        else $error("result word late");

endmodule

bind sparse_set_valid_array sset_chk u_sset_chk (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_valid      (s_valid),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_status     (m_status),
    .m_read_value (m_read_value)
);

// File: bench/tb.sv
// testbench for the sparse set table: directed rows, then random get/set words checked by a predictor
`timescale 1ns / 100ps

module tb;
    import sset_pkg::*;

    localparam bit KIND_GET = 1'b0;
    localparam bit KIND_SET = 1'b1;
    localparam int TBL = DEPTH_DEF;
    localparam logic [VALUE_W-1:0] VAL_MAX = '1;
    localparam int PHASE_WORDS = 60;

    typedef struct {
        status_t            st;
        logic [VALUE_W-1:0] rv;
    } answer_t;

    typedef struct {
        bit                 is_cfg;
        int                 size;
        bit                 kind;
        logic [INDEX_W-1:0] idx;
        logic [VALUE_W-1:0] val;
        bit                 typed;
        status_t            st;
        logic [VALUE_W-1:0] rv;
    } stim_row_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [SIZE_W-1:0]  cfg_data;
    logic               s_valid;
    logic               s_ready;
    logic               s_kind;
    logic [INDEX_W-1:0] s_index;
    logic [VALUE_W-1:0] s_value;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_status;
    logic [VALUE_W-1:0] m_read_value;

    sparse_set_valid_array #(.DEPTH(TBL)) u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_kind       (s_kind),
        .s_index      (s_index),
        .s_value      (s_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_read_value (m_read_value)
    );

    // predicted table contents
    logic [INDEX_W-1:0] pos_mem   [TBL];
    logic [INDEX_W-1:0] trace_mem [TBL];
    logic [VALUE_W-1:0] val_mem   [TBL];
    int                 slot_fill;
    int                 size_used;

    answer_t   pending_answers [$];
    stim_row_t dir_rows [$];
    answer_t   no_answer;

    int errors;
    int words_sent;
    int sizes_tried;
    int ready_hold;
    int status_seen [3];
    bit quiet;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [INDEX_W-1:0] pick_index(int sz, int base);
        int r;
        int lim;
        r = $urandom_range(0, 99);
        lim = (sz < 1) ? 1 : ((sz > TBL) ? TBL : sz);
        if (r < 65) return INDEX_W'((base + $urandom_range(0, 15)) % lim);
        if (r < 80) return INDEX_W'((r & 1) ? lim : lim - 1);
        return INDEX_W'($urandom_range(0, TBL - 1));
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return '0;
        if (r < 10) return VAL_MAX;
        return VALUE_W'($urandom);
    endfunction

    function automatic answer_t apply_access(bit kind, logic [INDEX_W-1:0] idx,
                                             logic [VALUE_W-1:0] val);
        answer_t            a;
        logic [INDEX_W-1:0] p;
        bit                 hit;
        a.st = STATUS_OK;
        a.rv = '0;
        if (int'(idx) >= size_used) begin
            a.st = STATUS_RANGE;
            return a;
        end
        p = pos_mem[idx];
        hit = (int'(p) < slot_fill) && (trace_mem[p] == idx);
        if (kind == KIND_GET) begin
            if (hit) a.rv = val_mem[idx];
            else a.st = STATUS_EMPTY;
        end else if (hit) begin
            val_mem[idx] = val;
        end else if (slot_fill < TBL) begin
            trace_mem[slot_fill] = idx;
            pos_mem[idx] = INDEX_W'(slot_fill);
            slot_fill++;
            val_mem[idx] = val;
        end
        return a;
    endfunction

    task automatic add_row(bit is_cfg, int size, bit kind, int idx, logic [VALUE_W-1:0] val,
                           bit typed, status_t st, logic [VALUE_W-1:0] rv);
        stim_row_t row;
        row.is_cfg = is_cfg;
        row.size   = size;
        row.kind   = kind;
        row.idx    = INDEX_W'(idx);
        row.val    = val;
        row.typed  = typed;
        row.st     = st;
        row.rv     = rv;
        dir_rows.push_back(row);
    endtask

    task automatic send_word(bit kind, logic [INDEX_W-1:0] idx, logic [VALUE_W-1:0] val,
                             bit typed, answer_t fixed);
        int      gap;
        answer_t a;
        gap = quiet ? 0 : pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_index <= idx;
        s_value <= val;
        do @(posedge aclk); while (!s_ready);
        a = apply_access(kind, idx, val);
        pending_answers.push_back(typed ? fixed : a);
        words_sent++;
    endtask

    task automatic wait_idle(int extra);
        s_valid <= 1'b0;
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    task automatic write_size(int sz);
        wait_idle(4);
        cfg_valid <= 1'b1;
        cfg_data  <= SIZE_W'(sz);
        do @(posedge aclk); while (!cfg_ready);
        size_used = sz;
        sizes_tried++;
        cfg_valid <= 1'b0;
    endtask

    // result side stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            ready_hold <= 0;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            m_ready <= ($urandom_range(0, 3) != 0);
            ready_hold <= pick_gap();
        end
    end

    always @(posedge aclk) begin
        answer_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                $display("%0t: unexpected result word: status %0d value %0h",
                         $time, m_status, m_read_value);
                errors++;
            end else begin
                e = pending_answers.pop_front();
                if (m_status !== e.st) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, e.st, m_status);
                    errors++;
                end
                if (m_read_value !== e.rv) begin
                    $display("%0t: read_value mismatch: expected %0h actual %0h",
                             $time, e.rv, m_read_value);
                    errors++;
                end
                if (m_status < 3) status_seen[m_status]++;
            end
        end
    end

    initial begin
        int        phase_sizes [10];
        int        order [TBL];
        int        base;
        int        j;
        int        t;
        stim_row_t row;
        aresetn   <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        s_valid   <= 1'b0;
        s_kind    <= KIND_GET;
        s_index   <= '0;
        s_value   <= '0;
        for (int i = 0; i < TBL; i++) begin
            pos_mem[i]   = '0;
            trace_mem[i] = '0;
            val_mem[i]   = '0;
        end
        slot_fill  = 0;
        size_used  = TBL;
        errors     = 0;
        words_sent = 0;
        sizes_tried = 0;
        quiet      = 1'b0;
        no_answer.st = STATUS_OK;
        no_answer.rv = '0;
        for (int i = 0; i < 3; i++) status_seen[i] = 0;
        phase_sizes = '{1024, 1, 2047, 17, 0, 300, 1023, 64, 2, 512};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        add_row(0, 0, KIND_GET, 0, '0, 1, STATUS_EMPTY, '0);
        add_row(0, 0, KIND_GET, 1023, VAL_MAX, 1, STATUS_EMPTY, '0);
        add_row(0, 0, KIND_SET, 0, VAL_MAX, 1, STATUS_OK, '0);
        add_row(0, 0, KIND_GET, 0, '0, 1, STATUS_OK, VAL_MAX);
        add_row(0, 0, KIND_SET, 1023, '0, 1, STATUS_OK, '0);
        add_row(0, 0, KIND_GET, 1023, '0, 1, STATUS_OK, '0);
        add_row(0, 0, KIND_SET, 0, 31'h2AAA_AAAA, 0, STATUS_OK, '0);
        add_row(0, 0, KIND_GET, 0, '0, 0, STATUS_OK, '0);
        add_row(0, 0, KIND_SET, 0, 31'h5555_5555, 0, STATUS_OK, '0);
        add_row(0, 0, KIND_GET, 0, '0, 0, STATUS_OK, '0);
        add_row(0, 0, KIND_GET, 512, '0, 1, STATUS_EMPTY, '0);
        add_row(1, 4, KIND_GET, 0, '0, 0, STATUS_OK, '0);
        add_row(0, 0, KIND_GET, 5, '0, 1, STATUS_RANGE, '0);
        add_row(0, 0, KIND_SET, 4, VAL_MAX, 1, STATUS_RANGE, '0);
        add_row(0, 0, KIND_SET, 3, 31'd12345, 0, STATUS_OK, '0);
        add_row(0, 0, KIND_GET, 3, '0, 0, STATUS_OK, '0);
        add_row(0, 0, KIND_GET, 1023, '0, 1, STATUS_RANGE, '0);
        add_row(1, 0, KIND_GET, 0, '0, 0, STATUS_OK, '0);
        add_row(0, 0, KIND_GET, 0, '0, 1, STATUS_RANGE, '0);
        add_row(0, 0, KIND_SET, 0, VAL_MAX, 1, STATUS_RANGE, '0);
        add_row(1, 1, KIND_GET, 0, '0, 0, STATUS_OK, '0);
        add_row(0, 0, KIND_GET, 0, '0, 0, STATUS_OK, '0);
        add_row(0, 0, KIND_SET, 1, VAL_MAX, 1, STATUS_RANGE, '0);
        add_row(1, 1024, KIND_GET, 0, '0, 0, STATUS_OK, '0);
        add_row(0, 0, KIND_GET, 1023, '0, 0, STATUS_OK, '0);
        add_row(0, 0, KIND_GET, 3, '0, 0, STATUS_OK, '0);
        add_row(1, 2047, KIND_GET, 0, '0, 0, STATUS_OK, '0);
        add_row(0, 0, KIND_GET, 1023, '0, 0, STATUS_OK, '0);
        add_row(0, 0, KIND_SET, 1000, 31'd1, 0, STATUS_OK, '0);
        add_row(0, 0, KIND_GET, 1000, '0, 0, STATUS_OK, '0);

        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            if (row.is_cfg) begin
                write_size(row.size);
            end else begin
                no_answer.st = row.st;
                no_answer.rv = row.rv;
                send_word(row.kind, row.idx, row.val, row.typed, no_answer);
            end
        end

        for (int p = 0; p < 10; p++) begin
            write_size(phase_sizes[p]);
            quiet = (p == 3) || (p == 7);
            base = $urandom_range(0, TBL - 1);
            if (phase_sizes[p] > 0) base = base % ((phase_sizes[p] > TBL) ? TBL : phase_sizes[p]);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                if (k % 40 == 39) base = (base + $urandom_range(1, 64)) % TBL;
                send_word($urandom_range(0, 1), pick_index(phase_sizes[p], base),
                          pick_value(), 0, no_answer);
            end
        end

        // fill every slot of the trace, then keep working on a full table
        write_size(TBL);
        quiet = 1'b0;
        for (int i = 0; i < TBL; i++) order[i] = i;
        for (int i = TBL - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        for (int i = 0; i < TBL; i++) begin
            send_word(KIND_SET, INDEX_W'(order[i]), pick_value(), 0, no_answer);
        end
        for (int k = 0; k < 150; k++) begin
            send_word($urandom_range(0, 1), INDEX_W'($urandom_range(0, TBL - 1)),
                      pick_value(), 0, no_answer);
        end

        wait_idle(10);
        $display("run covered %0d words over %0d table sizes, trace filled to %0d slots",
                 words_sent, sizes_tried, slot_fill);
        $display("answers seen: %0d ok, %0d empty, %0d out of range",
                 status_seen[0], status_seen[1], status_seen[2]);
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #15_000_000;
        $display("timeout waiting for the table");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
